// ===== sv/sqk_pkg.sv =====
// sqk_pkg: types, constants and small lookup functions for the squawk sighting cache
// shared by the config, controller, datapath and checker files; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sqk_pkg;

  // table geometry and counters
  localparam int unsigned TABLE_AW   = 12;
  localparam int unsigned CNT_W      = 16;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [3:0] MIN_PHASES  = 4'd3;

  // stream word layout
  localparam int unsigned S_DATA_W   = 88;
  localparam int unsigned M_DATA_W   = 8;
  localparam int unsigned CODE_LSB   = 0;
  localparam int unsigned PHASE_LSB  = 16;
  localparam int unsigned ALT_LSB    = 20;
  localparam int unsigned TS_LSB     = 38;
  localparam int unsigned TS_W       = 48;
  localparam int unsigned ALT_W      = 18;

  // operation codes carried in tuser
  localparam logic [1:0] OP_DETECT   = 2'd0;
  localparam logic [1:0] OP_MARK_SQK = 2'd1;
  localparam logic [1:0] OP_MARK_ALT = 2'd2;

  // register map
  localparam int unsigned CFG_AW     = 4;
  localparam logic [1:0] REG_TTL     = 2'd0;
  localparam logic [1:0] REG_MAX_GAP = 2'd1;
  localparam logic [1:0] REG_MIN_GAP = 2'd2;
  localparam logic [31:0] TTL_RST     = 32'd60000000;
  localparam logic [31:0] MAX_GAP_RST = 32'd12000000;
  localparam logic [31:0] MIN_GAP_RST = 32'd12000;

  // altitude to gillham conversion
  localparam logic [18:0] ALT_BIAS     = 19'd49;
  localparam logic [17:0] DIV100_MUL   = 18'd167773;  // ceil(2^24 / 100)
  localparam logic [10:0] DIV5_MUL     = 11'd1639;    // ceil(2^13 / 5)
  localparam logic [10:0] N_OFFSET     = 11'd12;

  typedef struct packed {
    logic [31:0] ttl_window;
    logic [31:0] max_prf_gap;
    logic [31:0] min_prf_gap;
  } sqk_cfg_t;

  typedef struct packed {
    logic clear;     // write zero at the sweep address
    logic load;      // take the input word and read its entry
    logic alt_div;   // altitude step: divide by 100
    logic alt_mod;   // altitude step: offset, clamp, divide by 5
    logic alt_read;  // altitude step: look up code, read its entry
    logic commit;    // write the entry back and load the result
  } sqk_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_alt;
    logic out_free;
  } sqk_sts_t;

  function automatic logic [2:0] fold8(input logic [3:0] x);
    fold8 = x[3] ? 3'(4'd15 - x) : x[2:0];
  endfunction

  function automatic logic [2:0] fives_lut(input logic [2:0] r);
    case (r)
      3'd0:    fives_lut = 3'd4;
      3'd1:    fives_lut = 3'd6;
      3'd2:    fives_lut = 3'd2;
      3'd3:    fives_lut = 3'd3;
      3'd4:    fives_lut = 3'd1;
      default: fives_lut = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] tens_lut(input logic [2:0] x);
    case (x)
      3'd0:    tens_lut = 3'd0;
      3'd1:    tens_lut = 3'd4;
      3'd2:    tens_lut = 3'd6;
      3'd3:    tens_lut = 3'd2;
      3'd4:    tens_lut = 3'd3;
      3'd5:    tens_lut = 3'd7;
      3'd6:    tens_lut = 3'd5;
      default: tens_lut = 3'd1;
    endcase
  endfunction

  // drop the top bit of each nibble: A4A2A1 B C D
  function automatic logic [TABLE_AW-1:0] octal_index(input logic [15:0] w);
    octal_index = {w[14:12], w[10:8], w[6:4], w[2:0]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/sqk_cfg.sv =====
// sqk_cfg: register file behind the configuration port
// depends on sqk_pkg for the register map and reset values
`timescale 1ns / 1ps
`default_nettype none

module sqk_cfg
  import sqk_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output sqk_cfg_t               cfg_o
);

  sqk_cfg_t    cfg_q;
  logic        wr_en;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ttl_window  <= TTL_RST;
      cfg_q.max_prf_gap <= MAX_GAP_RST;
      cfg_q.min_prf_gap <= MIN_GAP_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TTL:     cfg_q.ttl_window  <= pwdata;
        REG_MAX_GAP: cfg_q.max_prf_gap <= pwdata;
        REG_MIN_GAP: cfg_q.min_prf_gap <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TTL:     prdata = cfg_q.ttl_window;
      REG_MAX_GAP: prdata = cfg_q.max_prf_gap;
      REG_MIN_GAP: prdata = cfg_q.min_prf_gap;
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/sqk_ctrl.sv =====
// sqk_ctrl: sequencer for the clearing pass, altitude conversion and entry update
// depends on sqk_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module sqk_ctrl
  import sqk_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_valid_i,
  input  wire sqk_sts_t sts_i,
  output logic          s_ready_o,
  output sqk_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALT_DIV,
    ST_ALT_MOD,
    ST_ALT_LOOK,
    ST_UPDATE
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_valid_i) state_q <= sts_i.in_alt ? ST_ALT_DIV : ST_UPDATE;
        end
        ST_ALT_DIV:  state_q <= ST_ALT_MOD;
        ST_ALT_MOD:  state_q <= ST_ALT_LOOK;
        ST_ALT_LOOK: state_q <= ST_UPDATE;
        ST_UPDATE: begin
          // hold until the output register can take the word
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  assign s_ready_o       = (state_q == ST_IDLE);
  assign cmd_o.clear     = (state_q == ST_CLEAR);
  assign cmd_o.load      = (state_q == ST_IDLE) & s_valid_i;
  assign cmd_o.alt_div   = (state_q == ST_ALT_DIV);
  assign cmd_o.alt_mod   = (state_q == ST_ALT_MOD);
  assign cmd_o.alt_read  = (state_q == ST_ALT_LOOK);
  assign cmd_o.commit    = (state_q == ST_UPDATE) & sts_i.out_free;

endmodule

`default_nettype wire

// ===== sv/sqk_dp.sv =====
// sqk_dp: sighting table memory, altitude conversion, entry update and output register
// depends on sqk_pkg; driven by commands from sqk_ctrl
`timescale 1ns / 1ps
`default_nettype none

module sqk_dp
  import sqk_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sqk_cmd_t            cmd_i,
  input  wire sqk_cfg_t            cfg_i,
  input  wire logic [S_DATA_W-1:0] s_data_i,
  input  wire logic [1:0]          s_user_i,
  input  wire logic                m_ready_i,
  output sqk_sts_t                 sts_o,
  output logic                     m_valid_o,
  output logic      [M_DATA_W-1:0] m_data_o
);

  localparam int unsigned DEPTH = 1 << TABLE_AW;

  typedef struct packed {
    logic [TIME_BITS-1:0] last;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     total;
  } entry_t;

  entry_t mem [DEPTH];

  // item registers
  logic [1:0]           op_q;
  logic [3:0]           phase_q;
  logic [ALT_W-1:0]     alt_q;
  logic [TIME_BITS-1:0] ts_q;
  logic [TABLE_AW-1:0]  idx_q;
  entry_t               rd_q;
  logic [TABLE_AW-1:0]  clr_cnt_q;
  logic                 out_valid_q;
  logic                 out_bit_q;

  // altitude conversion registers
  logic [10:0] q_q;
  logic        neg_q;
  logic [10:0] n_q;
  logic [8:0]  m_q;

  // ---------------- altitude to gillham ----------------
  logic [18:0] biased;
  logic [17:0] abs_alt;
  logic [35:0] prod100;
  logic [10:0] n_d;
  logic [21:0] prod5;
  logic [7:0]  tens;
  logic [10:0] tens_x10;
  logic [3:0]  rem10;
  logic [2:0]  rem_fold;
  logic [2:0]  g_a, g_b, g_c, g_d;
  logic [TABLE_AW-1:0] alt_idx;

  assign biased  = {alt_q[ALT_W-1], alt_q} + ALT_BIAS;
  assign abs_alt = biased[18] ? 18'(~biased + 19'd1) : biased[17:0];
  assign prod100 = abs_alt * DIV100_MUL;

  always_comb begin
    if (neg_q) begin
      n_d = (q_q > N_OFFSET) ? 11'd0 : (N_OFFSET - q_q);
    end else begin
      n_d = q_q + N_OFFSET;
    end
  end

  assign prod5 = n_d * DIV5_MUL;

  // n mod 10 from floor(n/5) halved
  assign tens     = m_q[8:1];
  assign tens_x10 = (11'(tens) << 3) + (11'(tens) << 1);
  assign rem10    = 4'(n_q - tens_x10);
  assign rem_fold = (rem10 > 4'd4) ? 3'(4'd9 - rem10) : rem10[2:0];

  assign g_c     = fives_lut(rem_fold);
  assign g_b     = tens_lut(fold8(m_q[3:0]));
  assign g_a     = tens_lut(fold8(m_q[6:3]));
  assign g_d     = tens_lut(fold8({1'b0, m_q[8:6]}));
  assign alt_idx = {g_a, g_b, g_c, g_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= s_user_i;
      phase_q <= s_data_i[PHASE_LSB +: 4];
      alt_q   <= s_data_i[ALT_LSB +: ALT_W];
      ts_q    <= TIME_BITS'(s_data_i[TS_LSB +: TS_W]);
    end
    if (cmd_i.alt_div) begin
      q_q   <= prod100[34:24];
      neg_q <= biased[18];
    end
    if (cmd_i.alt_mod) begin
      n_q <= n_d;
      m_q <= prod5[21:13];
    end
  end

  // ---------------- entry update ----------------
  logic [TIME_BITS-1:0] gap;
  logic                 is_det;
  logic                 is_mark;
  entry_t               upd;
  logic                 upd_we;
  logic                 upd_bit;

  assign gap     = ts_q - rd_q.last;
  assign is_det  = (op_q == OP_DETECT) && (phase_q >= MIN_PHASES);
  assign is_mark = (op_q == OP_MARK_SQK) || (op_q == OP_MARK_ALT);

  always_comb begin
    upd     = rd_q;
    upd_we  = is_det | is_mark;
    upd_bit = 1'b0;
    if (is_mark) begin
      upd.last  = ts_q;
      upd.total = COUNT_MAX;
    end else if (is_det) begin
      if (rd_q.last != '0) begin
        if (gap > TIME_BITS'(cfg_i.ttl_window)) begin
          upd.hits  = '0;
          upd.total = '0;
        end else if (gap > TIME_BITS'(cfg_i.max_prf_gap)) begin
          // a sweep counts only with more than two hits in it
          if ((rd_q.hits > 16'd2) && (rd_q.total != COUNT_MAX)) begin
            upd.total = rd_q.total + 16'd1;
          end
          upd.hits = '0;
        end else if (gap > TIME_BITS'(cfg_i.min_prf_gap)) begin
          if (rd_q.hits != COUNT_MAX) upd.hits = rd_q.hits + 16'd1;
        end
      end
      upd.last = ts_q;
      upd_bit  = (upd.total > 16'd1);
    end
  end

  // ---------------- table memory ----------------
  logic                mem_we;
  logic [TABLE_AW-1:0] mem_wa;
  entry_t              mem_wd;
  logic                mem_re;
  logic [TABLE_AW-1:0] mem_ra;

  assign mem_we = cmd_i.clear | (cmd_i.commit & upd_we);
  assign mem_wa = cmd_i.clear ? clr_cnt_q : idx_q;
  assign mem_wd = cmd_i.clear ? entry_t'('0) : upd;
  assign mem_re = cmd_i.load | cmd_i.alt_read;
  assign mem_ra = cmd_i.load ? octal_index(s_data_i[CODE_LSB +: 16]) : alt_idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) idx_q <= mem_ra;
    if (cmd_i.commit) out_bit_q <= upd_bit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + TABLE_AW'(1);
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last = &clr_cnt_q;
  assign sts_o.in_alt   = (s_user_i == OP_MARK_ALT);
  assign sts_o.out_free = ~out_valid_q | m_ready_i;

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {{(M_DATA_W-1){1'b0}}, out_bit_q};

endmodule

`default_nettype wire

// ===== sv/squawk_sighting_cache.sv =====
// squawk_sighting_cache: top level of the mode a sighting cache
// instantiates sqk_cfg, sqk_ctrl and sqk_dp; types from sqk_pkg
//
//   channel   direction  handshake                 word
//   s_axis    in         tvalid / tready           tuser op, tdata code/phases/alt/time
//   m_axis    out        tvalid / tready           tdata is_valid
//   apb       in/out     psel penable pwrite       three 32-bit registers at 0x0 0x4 0x8
//
// detection and squawk marks: entry read on accept, write-back when the output is free
// altitude marks add three steps first: the divide-by-100, divide-by-5 and lookup
// one item at a time; the single table port sets the pace
// after reset a clearing pass zeroes all 4096 entries, with tready low until it ends
// a result waits in the output register; a stalled m_axis holds the write-back
`timescale 1ns / 1ps
`default_nettype none

module squawk_sighting_cache
  import sqk_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // tuser: op[1:0]
  // tdata: code[15:0], phase_count[19:16], altitude_ft[37:20], timestamp[85:38], zero[87:86]
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  input  wire logic [1:0]          s_axis_tuser,
  // tdata: is_valid[0], zero[7:1]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [M_DATA_W-1:0] m_axis_tdata,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CFG_AW-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  sqk_cfg_t cfg;
  sqk_cmd_t cmd;
  sqk_sts_t sts;

  sqk_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sqk_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  sqk_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cfg_i     (cfg),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .m_ready_i (m_axis_tready),
    .sts_o     (sts),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== sv/sqk_checker.sv =====
// sqk_checker: port-level checks on the sighting cache, bound to the top level
// depends on sqk_pkg for the op codes and stream widths
`timescale 1ns / 1ps
`default_nettype none

module sqk_checker
  import sqk_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [1:0]          s_axis_tuser,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [M_DATA_W-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid & s_axis_tready;

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted back to back");

  // altitude marks go through the conversion steps
  a_alt_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == OP_MARK_ALT) |=> !s_axis_tready ##1 !s_axis_tready
      ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("altitude mark finished too early");

  // a result only appears at the end of an item
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without an item at work");

endmodule

bind squawk_sighting_cache sqk_checker u_sqk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/squawk_sighting_cache_tb.sv =====
// squawk_sighting_cache_tb: self-checking bench for the mode a sighting cache
// drives stream words and apb writes, predicts is_valid per word; needs sqk_pkg and the rtl
`timescale 1ns / 1ps

module squawk_sighting_cache_tb;
  import sqk_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 1000000;
  localparam int unsigned SETTLE = 8;
  // c from the fives group, a/b/d from the tens group, lowest entry first
  localparam logic [14:0] FIVES_CODE = {3'd1, 3'd3, 3'd2, 3'd6, 3'd4};
  localparam logic [23:0] TENS_CODE = {3'd1, 3'd5, 3'd7, 3'd3, 3'd2, 3'd6, 3'd4, 3'd0};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;   // code, phase_count, altitude_ft, timestamp, zero pad
  logic [1:0] s_axis_tuser;            // op
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;   // is_valid, zero pad
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // shadow of the sighting store and its windows
  logic [47:0] seen_at [4096];
  logic [15:0] hits_in_sweep [4096];
  logic [15:0] sweeps_seen [4096];
  logic [31:0] ttl_win;
  logic [31:0] max_gap;
  logic [31:0] min_gap;

  logic pending_valid [$];
  logic want_valid;
  logic [11:0] pool_slot [4];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_seq;
  int unsigned hold_seen;
  int unsigned hold_len;
  int unsigned hold_left;

  squawk_sighting_cache #(.TIME_BITS(48)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [11:0] code_slot(input logic [15:0] w);
    code_slot = {w[14:12], w[10:8], w[6:4], w[2:0]};
  endfunction

  // spread a slot over a mode a word, the nibble top bits taken from spare
  function automatic logic [15:0] slot_to_code(input logic [11:0] s, input logic [3:0] spare);
    slot_to_code = {spare[3], s[11:9], spare[2], s[8:6], spare[1], s[5:3], spare[0], s[2:0]};
  endfunction

  function automatic logic [2:0] fold_tens(input int unsigned x);
    int unsigned v;
    v = x & 15;
    if (v > 7) v = 15 - v;
    fold_tens = TENS_CODE[3*v +: 3];
  endfunction

  function automatic logic [15:0] gillham_of(input logic signed [17:0] alt);
    int n;
    int unsigned r;
    int unsigned m;
    n = (int'(alt) + 49) / 100 + 12;
    if (n < 0) n = 0;
    r = n % 10;
    if (r > 4) r = 9 - r;
    m = n / 5;
    gillham_of = {1'b0, fold_tens(m >> 3), 1'b0, fold_tens(m), 1'b0, FIVES_CODE[3*r +: 3],
                  1'b0, fold_tens(m >> 6)};
  endfunction

  // apply one accepted word to the shadow store, return the expected is_valid
  function automatic logic note_sighting(input logic [1:0] op, input logic [15:0] code,
                                         input logic [3:0] phases,
                                         input logic signed [17:0] alt,
                                         input logic [47:0] ts);
    logic [11:0] s;
    logic [47:0] gap;
    note_sighting = 1'b0;
    case (op)
      OP_MARK_SQK, OP_MARK_ALT: begin
        s = (op == OP_MARK_SQK) ? code_slot(code) : code_slot(gillham_of(alt));
        seen_at[s] = ts;
        sweeps_seen[s] = COUNT_MAX;
      end
      OP_DETECT: begin
        if (phases >= MIN_PHASES) begin
          s = code_slot(code);
          if (seen_at[s] != 48'd0) begin
            gap = ts - seen_at[s];
            if (gap > {16'd0, ttl_win}) begin
              hits_in_sweep[s] = 16'd0;
              sweeps_seen[s] = 16'd0;
            end else if (gap > {16'd0, max_gap}) begin
              if (hits_in_sweep[s] > 16'd2 && sweeps_seen[s] != COUNT_MAX)
                sweeps_seen[s] = sweeps_seen[s] + 16'd1;
              hits_in_sweep[s] = 16'd0;
            end else if (gap > {16'd0, min_gap}) begin
              if (hits_in_sweep[s] != COUNT_MAX) hits_in_sweep[s] = hits_in_sweep[s] + 16'd1;
            end
          end
          seen_at[s] = ts;
          note_sighting = (sweeps_seen[s] > 16'd1);
        end
      end
      default: ;
    endcase
  endfunction

  // gap drawn against the current windows, with the edges of each band favoured
  function automatic logic [63:0] pick_gap();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] r64;
    int unsigned k;
    r64 = {$urandom, $urandom};
    k = $urandom_range(0, 19);
    if (k < 3) begin
      lo = 64'd0;
      hi = 64'(min_gap);
    end else if (k < 11) begin
      lo = 64'(min_gap) + 64'd1;
      hi = 64'(max_gap);
    end else if (k < 16) begin
      lo = 64'(max_gap) + 64'd1;
      hi = 64'(ttl_win);
    end else if (k < 17) begin
      lo = 64'(ttl_win) + 64'd1;
      hi = 64'h0000_7FFF_FFFF_FFFF;
    end else begin
      case ($urandom_range(0, 5))
        0: lo = 64'(min_gap);
        1: lo = 64'(min_gap) + 64'd1;
        2: lo = 64'(max_gap);
        3: lo = 64'(max_gap) + 64'd1;
        4: lo = 64'(ttl_win);
        default: lo = 64'(ttl_win) + 64'd1;
      endcase
      hi = lo;
    end
    if (hi < lo) pick_gap = lo;
    else pick_gap = lo + r64 % (hi - lo + 64'd1);
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [15:0] code,
                           input logic [3:0] phases, input logic signed [17:0] alt,
                           input logic [47:0] ts);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {2'b00, ts, alt, phases, code};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pending_valid.push_back(note_sighting(op, code, phases, alt, ts));
  endtask

  // drop valid, let every result come home, then let the pipe empty
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_valid.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_windows(input logic [31:0] ttl, input logic [31:0] maxg,
                             input logic [31:0] ming);
    wait_idle();
    apb_write(REG_TTL, ttl);
    apb_write(REG_MAX_GAP, maxg);
    apb_write(REG_MIN_GAP, ming);
    ttl_win = ttl;
    max_gap = maxg;
    min_gap = ming;
  endtask

  // mostly well-formed sightings of a few codes, the rest noise, marks and unused ops
  task automatic run_sightings(input int unsigned n);
    int unsigned r;
    int a;
    logic [11:0] s;
    logic [47:0] ts;
    for (int i = 0; i < 4; i++) pool_slot[i] = 12'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      s = pool_slot[$urandom_range(0, 3)];
      ts = 48'(64'(seen_at[s]) + pick_gap());
      a = int'($urandom_range(0, 127900)) - 1200;
      if (r < 72)
        send_word(OP_DETECT, slot_to_code(s, 4'($urandom)), 4'($urandom_range(3, 15)),
                  18'($urandom), ts);
      else if (r < 82)
        send_word(OP_DETECT, 16'($urandom), 4'($urandom), 18'($urandom),
                  48'({$urandom, $urandom}));
      else if (r < 88)
        send_word(OP_MARK_SQK, slot_to_code(s, 4'($urandom)), 4'($urandom), 18'($urandom), ts);
      else if (r < 95)
        send_word(OP_MARK_ALT, 16'($urandom), 4'($urandom), 18'(a),
                  48'({$urandom, $urandom}));
      else
        send_word(OP_UNUSED, 16'($urandom), 4'($urandom), 18'($urandom),
                  48'({$urandom, $urandom}));
    end
  endtask

  task automatic test_directed();
    logic [47:0] t;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_word(OP_DETECT, 16'h0000, 4'd3, 18'sd0, 48'd1);
    send_word(OP_DETECT, 16'hFFFF, 4'd15, 18'h3FFFF, 48'hFFFF_FFFF_FFFF);
    // too few phases
    send_word(OP_DETECT, 16'h0000, 4'd2, 18'sd0, 48'd100);
    send_word(OP_UNUSED, 16'hFFFF, 4'd15, 18'h3FFFF, 48'hFFFF_FFFF_FFFF);
    // a mark, then a detection of the same slot through other spare bits
    send_word(OP_MARK_SQK, 16'h1234, 4'd0, 18'sd0, 48'd5000);
    send_word(OP_DETECT, 16'h9ABC, 4'd4, 18'sd0, 48'd5100);
    send_word(OP_DETECT, 16'h1234, 4'd3, 18'sd0, 48'd13_005_100);
    send_word(OP_MARK_ALT, 16'h0000, 4'd0, 18'sd126700, 48'd7);
    send_word(OP_MARK_ALT, 16'h0000, 4'd0, -18'sd1200, 48'd8);
    // altitude so low the step count goes negative
    send_word(OP_MARK_ALT, 16'h0000, 4'd0, 18'h20000, 48'd9);
    send_word(OP_MARK_ALT, 16'hFFFF, 4'd0, 18'sd2350, 48'd11);
    // a zero time leaves the entry looking unseen
    send_word(OP_DETECT, 16'h0777, 4'd3, 18'sd0, 48'd0);
    send_word(OP_DETECT, 16'h0777, 4'd3, 18'sd0, 48'd20000);
    // the gap wraps through zero, then a gap past the ttl
    send_word(OP_DETECT, 16'h0555, 4'd3, 18'sd0, 48'hFFFF_FFFF_FF00);
    send_word(OP_DETECT, 16'h0555, 4'd3, 18'sd0, 48'h2F00);
    send_word(OP_DETECT, 16'h0555, 4'd3, 18'sd0, 48'h2F00 + 48'd70_000_000);
    // two full sweeps of three hits each
    t = 48'd1000;
    send_word(OP_DETECT, 16'h0321, 4'd5, 18'sd0, t);
    for (int k = 0; k < 8; k++) begin
      t = t + ((k % 4 == 3) ? 48'd13_000_000 : 48'd20_000);
      send_word(OP_DETECT, 16'h0321, 4'd5, 18'sd0, t);
    end
  endtask

  task automatic test_sweep_counting();
    set_windows(32'd200000, 32'd2000, 32'd20);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_sightings(450);
  endtask

  task automatic test_sender_gaps();
    set_windows(32'hFFFF_FFFF, 32'd1000000, 32'd1000);
    src_idle_pct = 75;
    sink_stall_pct = 0;
    run_sightings(350);
  endtask

  task automatic test_receiver_stalls();
    set_windows(32'd5000, 32'd500, 32'd50);
    src_idle_pct = 0;
    sink_stall_pct = 75;
    run_sightings(300);
  endtask

  task automatic test_both_idle();
    set_windows(32'd0, 32'd0, 32'd0);
    src_idle_pct = 14;
    sink_stall_pct = 14;
    run_sightings(250);
  endtask

  task automatic test_wide_windows();
    set_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_sightings(200);
  endtask

  // minimum gap above the maximum: every long gap is a new sweep
  task automatic test_inverted_gaps();
    set_windows(32'd100000, 32'd100, 32'd5000);
    src_idle_pct = 14;
    sink_stall_pct = 14;
    run_sightings(150);
  endtask

  task automatic test_backpressure();
    set_windows(32'd100000, 32'd1000, 32'd10);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_len = 400;
    hold_seq = hold_seq + 1;
    run_sightings(40);
    wait_idle();
    run_sightings(40);
  endtask

  // receiver: random stalls, and a long hold whenever one is requested
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_valid.size() == 0) begin
        fail_cnt++;
        $display("%0t: word with none pending: expected none, actual is_valid=%0b",
                 $time, m_axis_tdata[0]);
      end else begin
        want_valid = pending_valid.pop_front();
        if (m_axis_tdata[0] !== want_valid) begin
          fail_cnt++;
          $display("%0t: is_valid mismatch: expected %0b, actual %0b",
                   $time, want_valid, m_axis_tdata[0]);
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("squawk_sighting_cache test failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_DETECT;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_cnt = 0;
    hold_seq = 0;
    hold_seen = 0;
    hold_len = 0;
    hold_left = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    ttl_win = TTL_RST;
    max_gap = MAX_GAP_RST;
    min_gap = MIN_GAP_RST;
    for (int i = 0; i < 4096; i++) begin
      seen_at[i] = 48'd0;
      hits_in_sweep[i] = 16'd0;
      sweeps_seen[i] = 16'd0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_sweep_counting();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_wide_windows();
    test_inverted_gaps();
    test_backpressure();
    wait_idle();

    if (fail_cnt == 0)
      $display("squawk_sighting_cache test passed");
    else
      $display("squawk_sighting_cache test failed");
    $finish;
  end

endmodule
